// ----- design/rpha_pkg.sv -----
// Shared types and constants for the record parse, hash and aggregate block.
package rpha_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam int VALUE_W = 11;
    localparam int SUM_W   = 43;
    localparam int COUNT_W = 32;
    localparam int SLOT_OUT_W = 10;
    localparam int ACCUM_W = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [ACCUM_W-1:0] ACCUM_MAX = 10'd99;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_LONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_VSTART = 2'd1,
        PH_INT    = 2'd2,
        PH_TENTHS = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_UPDATE
    } seq_state_t;

endpackage

// ----- design/record_parse_hash_aggregate.sv -----
// Top level: record parser, probing sequencer and the per-key aggregate table.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in      | in        | in_valid/in_stall  | data_byte
//   out     | out       | out_valid/out_stall| slot_index, new_key, record_value,
//           |           |                    | min_value, max_value, value_sum,
//           |           |                    | value_count, status
//
// Name and value bytes are accepted while in_stall is low. Unless the name
// is too long, the tenths byte starts a lookup: each slot probed is read and
// checked, each name byte is read and compared, or read and copied on insert,
// and the slot is written back. After reset a clearing pass empties every slot;
// in_stall stays high meanwhile. A pending result only holds back the next tenths beat.
module record_parse_hash_aggregate
    import rpha_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 1024,
    parameter int MAX_NAME_BYTES = 128
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [SLOT_OUT_W-1:0]        slot_index,
    output logic                         new_key,
    output logic signed [VALUE_W-1:0]    record_value,
    output logic signed [VALUE_W-1:0]    min_value,
    output logic signed [VALUE_W-1:0]    max_value,
    output logic signed [SUM_W-1:0]      value_sum,
    output logic [COUNT_W-1:0]           value_count,
    output logic [1:0]                   status
);
    localparam int SW  = $clog2(TABLE_ENTRIES);
    localparam int LW  = $clog2(MAX_NAME_BYTES + 2);
    localparam int NLW = $clog2(MAX_NAME_BYTES + 1);
    localparam int KAW = $clog2(MAX_NAME_BYTES);
    localparam int NAW = $clog2(TABLE_ENTRIES * MAX_NAME_BYTES);
    localparam int NAME_DEPTH = TABLE_ENTRIES * MAX_NAME_BYTES;
    localparam logic [SW-1:0] SLOT_LAST = SW'(TABLE_ENTRIES - 1);
    localparam logic [LW-1:0] KLEN_MAX  = LW'(MAX_NAME_BYTES);

    seq_state_t state_reg, state_next;
    phase_t     phase_reg;

    logic [SW-1:0]      hash_reg, hash_next, slot_reg, probe_reg, clr_reg;
    logic [LW-1:0]      klen_reg, len_reg, idx_reg, idx_inc;
    logic [ACCUM_W-1:0] accum_reg;
    logic               neg_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic out_valid_reg;
    logic [SLOT_OUT_W-1:0]     slot_out_reg;
    logic                      new_key_reg;
    logic signed [VALUE_W-1:0] rec_out_reg, min_out_reg, max_out_reg;
    logic signed [SUM_W-1:0]   sum_out_reg;
    logic [COUNT_W-1:0]        count_out_reg;
    status_t                   status_reg;

    // Slot table: one write and one read port, read address is the probe slot.
    logic [COUNT_W-1:0]        info_count [TABLE_ENTRIES];
    logic signed [VALUE_W-1:0] info_min   [TABLE_ENTRIES];
    logic signed [VALUE_W-1:0] info_max   [TABLE_ENTRIES];
    logic signed [SUM_W-1:0]   info_sum   [TABLE_ENTRIES];
    logic [NLW-1:0]            info_len   [TABLE_ENTRIES];
    logic [COUNT_W-1:0]        count_q;
    logic signed [VALUE_W-1:0] min_q, max_q;
    logic signed [SUM_W-1:0]   sum_q;
    logic [NLW-1:0]            len_q;

    logic [7:0] key_mem  [MAX_NAME_BYTES];
    logic [7:0] name_mem [NAME_DEPTH];
    logic [7:0] key_q, name_q;
    logic [NAW-1:0] name_addr;

    logic in_fire, out_fire, is_digit, finish, too_long, kb_we;
    logic info_we, name_we, advance, last_probe, emit_full;
    logic is_empty, len_match, bytes_eq, idx_last;
    logic [3:0] tenths;
    logic [VALUE_W-1:0] mag;
    logic signed [VALUE_W-1:0] v_new;
    logic [ACCUM_W-1:0] accum_sum;
    logic [SW-1:0]      wr_addr;
    logic [COUNT_W-1:0]        upd_count;
    logic signed [VALUE_W-1:0] upd_min, upd_max;
    logic signed [SUM_W-1:0]   upd_sum, value_ext;

    rpha_hash_step #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
        .hash      (hash_reg),
        .data_byte (data_byte),
        .hash_next (hash_next)
    );

    assign in_stall = (state_reg != ST_IDLE) || (phase_reg == PH_TENTHS && out_valid_reg);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign is_digit  = data_byte >= CHAR_ZERO && data_byte <= CHAR_NINE;
    assign tenths    = is_digit ? 4'(data_byte - CHAR_ZERO) : 4'd0;
    assign accum_sum = ACCUM_W'(accum_reg * ACCUM_W'(10)) + ACCUM_W'(tenths);
    assign mag       = VALUE_W'(accum_reg) * VALUE_W'(10) + VALUE_W'(tenths);
    assign v_new     = neg_reg ? -$signed(mag) : $signed(mag);
    assign finish    = in_fire && phase_reg == PH_TENTHS;
    assign too_long  = klen_reg > KLEN_MAX;
    assign kb_we     = in_fire && phase_reg == PH_NAME && data_byte != CHAR_SEMI
                       && !(klen_reg == '0 && (data_byte == CHAR_CR || data_byte == CHAR_LF))
                       && klen_reg < KLEN_MAX;

    assign is_empty   = count_q == '0;
    assign len_match  = LW'(len_q) == len_reg;
    assign bytes_eq   = key_q == name_q;
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_last   = idx_inc == len_reg;
    assign last_probe = probe_reg == SLOT_LAST;
    assign name_addr  = NAW'(slot_reg) * NAW'(MAX_NAME_BYTES) + NAW'(idx_reg);

    assign value_ext = SUM_W'(value_reg);
    assign upd_count = is_empty ? COUNT_W'(1)
                     : (count_q == COUNT_MAX ? count_q : count_q + 1'b1);
    assign upd_sum   = is_empty ? value_ext
                     : (count_q == COUNT_MAX ? sum_q : sum_q + value_ext);
    assign upd_min   = (is_empty || value_reg < min_q) ? value_reg : min_q;
    assign upd_max   = (is_empty || value_reg > max_q) ? value_reg : max_q;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (finish && !too_long)
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                priority if (is_empty)
                begin
                    state_next = (len_reg == '0) ? ST_UPDATE : ST_COPY_RD;
                end
                else if (len_match)
                begin
                    state_next = (len_reg == '0) ? ST_UPDATE : ST_CMP_RD;
                end
                else
                begin
                    state_next = last_probe ? ST_IDLE : ST_PROBE_RD;
                end
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK:
            begin
                priority if (bytes_eq)
                begin
                    state_next = idx_last ? ST_UPDATE : ST_CMP_RD;
                end
                else
                begin
                    state_next = last_probe ? ST_IDLE : ST_PROBE_RD;
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                state_next = idx_last ? ST_UPDATE : ST_COPY_RD;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        info_we = 1'b0;
        name_we = 1'b0;
        advance = 1'b0;
        wr_addr = slot_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                info_we = 1'b1;
                wr_addr = clr_reg;
            end
            ST_PROBE_CHK:
            begin
                advance = !is_empty && !len_match;
            end
            ST_CMP_CHK:
            begin
                advance = !bytes_eq;
            end
            ST_COPY_WR:
            begin
                name_we = 1'b1;
            end
            ST_UPDATE:
            begin
                info_we = 1'b1;
            end
            default:
            begin
                info_we = 1'b0;
            end
        endcase
    end

    assign emit_full = advance && last_probe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_NAME;
            hash_reg      <= '0;
            klen_reg      <= '0;
            accum_reg     <= '0;
            neg_reg       <= 1'b0;
            clr_reg       <= '0;
            slot_reg      <= '0;
            probe_reg     <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (in_fire)
            begin
                unique case (phase_reg)
                    PH_NAME:
                    begin
                        priority if (data_byte == CHAR_SEMI)
                        begin
                            phase_reg <= PH_VSTART;
                        end
                        else if (klen_reg == '0
                                 && (data_byte == CHAR_CR || data_byte == CHAR_LF))
                        begin
                            phase_reg <= PH_NAME;
                        end
                        else
                        begin
                            hash_reg <= hash_next;
                            if (klen_reg <= KLEN_MAX)
                            begin
                                klen_reg <= klen_reg + 1'b1;
                            end
                        end
                    end
                    PH_VSTART, PH_INT:
                    begin
                        phase_reg <= PH_INT;
                        // A minus sign counts only right after the semicolon.
                        priority if (phase_reg == PH_VSTART && data_byte == CHAR_MINUS)
                        begin
                            neg_reg <= 1'b1;
                        end
                        else if (data_byte == CHAR_POINT)
                        begin
                            phase_reg <= PH_TENTHS;
                        end
                        else if (is_digit)
                        begin
                            accum_reg <= (accum_sum > ACCUM_MAX) ? ACCUM_MAX : accum_sum;
                        end
                        else
                        begin
                            phase_reg <= PH_INT;
                        end
                    end
                    PH_TENTHS:
                    begin
                        value_reg <= v_new;
                        len_reg   <= klen_reg;
                        slot_reg  <= hash_reg;
                        probe_reg <= '0;
                        phase_reg <= PH_NAME;
                        hash_reg  <= '0;
                        klen_reg  <= '0;
                        accum_reg <= '0;
                        neg_reg   <= 1'b0;
                    end
                    default:
                    begin
                        phase_reg <= PH_NAME;
                    end
                endcase
            end
            if (state_reg == ST_PROBE_CHK && !advance)
            begin
                idx_reg <= '0;
            end
            if ((state_reg == ST_CMP_CHK && bytes_eq) || state_reg == ST_COPY_WR)
            begin
                idx_reg <= idx_inc;
            end
            if (advance && !last_probe)
            begin
                slot_reg  <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                probe_reg <= probe_reg + 1'b1;
            end
            if (state_reg == ST_UPDATE || emit_full || (finish && too_long))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && too_long)
        begin
            slot_out_reg  <= '0;
            new_key_reg   <= 1'b0;
            rec_out_reg   <= v_new;
            min_out_reg   <= '0;
            max_out_reg   <= '0;
            sum_out_reg   <= '0;
            count_out_reg <= '0;
            status_reg    <= STATUS_LONG;
        end
        else if (emit_full)
        begin
            slot_out_reg  <= '0;
            new_key_reg   <= 1'b0;
            rec_out_reg   <= value_reg;
            min_out_reg   <= '0;
            max_out_reg   <= '0;
            sum_out_reg   <= '0;
            count_out_reg <= '0;
            status_reg    <= STATUS_FULL;
        end
        else if (state_reg == ST_UPDATE)
        begin
            slot_out_reg  <= SLOT_OUT_W'(slot_reg);
            new_key_reg   <= is_empty;
            rec_out_reg   <= value_reg;
            min_out_reg   <= upd_min;
            max_out_reg   <= upd_max;
            sum_out_reg   <= upd_sum;
            count_out_reg <= upd_count;
            status_reg    <= STATUS_OK;
        end
    end

    // The read data of the slot table is registered and follows the probe slot in the next cycle.
    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_count[wr_addr] <= (state_reg == ST_CLEAR) ? '0 : upd_count;
            info_min[wr_addr]   <= upd_min;
            info_max[wr_addr]   <= upd_max;
            info_sum[wr_addr]   <= upd_sum;
            info_len[wr_addr]   <= len_reg[NLW-1:0];
        end
        count_q <= info_count[slot_reg];
        min_q   <= info_min[slot_reg];
        max_q   <= info_max[slot_reg];
        sum_q   <= info_sum[slot_reg];
        len_q   <= info_len[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (kb_we)
        begin
            key_mem[klen_reg[KAW-1:0]] <= data_byte;
        end
        key_q <= key_mem[idx_reg[KAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_addr] <= key_q;
        end
        name_q <= name_mem[name_addr];
    end

    assign out_valid    = out_valid_reg;
    assign slot_index   = slot_out_reg;
    assign new_key      = new_key_reg;
    assign record_value = rec_out_reg;
    assign min_value    = min_out_reg;
    assign max_value    = max_out_reg;
    assign value_sum    = sum_out_reg;
    assign value_count  = count_out_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_update_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> out_valid_reg)
        else $error("slot update did not produce a result beat");

    a_ok_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_OK |-> count_out_reg != '0)
        else $error("accepted record reports an empty slot");

    a_new_key_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_OK && new_key_reg
        |-> count_out_reg == COUNT_W'(1) && min_out_reg == rec_out_reg
            && max_out_reg == rec_out_reg)
        else $error("inserted key does not start from its own value");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_OK |-> min_out_reg <= max_out_reg)
        else $error("minimum exceeds maximum");
`endif

endmodule

// ----- design/rpha_hash_step.sv -----
// One step of the name hash: (hash * 31 + byte) reduced modulo the table size.
module rpha_hash_step
    import rpha_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
)
(
    input  logic [$clog2(TABLE_ENTRIES)-1:0] hash,
    input  logic [7:0]                       data_byte,
    output logic [$clog2(TABLE_ENTRIES)-1:0] hash_next
);
    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int XW = SW + 9;

    logic [XW-1:0] x;

    // The raw product stays below 64 table sizes, so six restoring
    // compare-and-subtract steps leave the remainder.
    always_comb
    begin
        x = (XW'(hash) << 5) - XW'(hash) + XW'(data_byte);
        for (int k = 5; k >= 0; k--)
        begin
            if (x >= (XW'(TABLE_ENTRIES) << k))
            begin
                x = x - (XW'(TABLE_ENTRIES) << k);
            end
        end
        hash_next = x[SW-1:0];
    end

endmodule
